// ===== hw/rtl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants of the line crossing counter: side and crossing
// codes, register indexes, configuration and controller interface structs.
// ----------------------------------------------------------------------------
package lcc_pkg;

	localparam int COORD_W   = 12;
	localparam int CENT_W    = 16;
	localparam int ID_W      = 8;
	localparam int CNT_W     = 32;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 72;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int ID_SPAN   = 256;

	localparam logic [2:0] REG_START_X = 3'd0;
	localparam logic [2:0] REG_START_Y = 3'd1;
	localparam logic [2:0] REG_END_X   = 3'd2;
	localparam logic [2:0] REG_END_Y   = 3'd3;
	localparam logic [2:0] REG_ENABLE  = 3'd4;

	typedef enum logic [1:0] {
		SIDE_NONE = 2'd0,
		SIDE_A    = 2'd1,
		SIDE_B    = 2'd2
	} side_t;

	typedef enum logic [1:0] {
		CROSS_NONE = 2'd0,
		CROSS_AB   = 2'd1,
		CROSS_BA   = 2'd2
	} cross_t;

	typedef enum logic [1:0] {
		ST_CLEAR  = 2'd0,
		ST_IDLE   = 2'd1,
		ST_UPDATE = 2'd2
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic               enable;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/lcc_cfg.sv =====
// ----------------------------------------------------------------------------
// lcc_cfg
// Register bank behind the APB-style port: counting line endpoints and the
// counting enable.
// ----------------------------------------------------------------------------
module lcc_cfg
	import lcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_X: cfg_q.start_x <= pwdata[COORD_W-1:0];
				REG_START_Y: cfg_q.start_y <= pwdata[COORD_W-1:0];
				REG_END_X:   cfg_q.end_x   <= pwdata[COORD_W-1:0];
				REG_END_Y:   cfg_q.end_y   <= pwdata[COORD_W-1:0];
				REG_ENABLE:  cfg_q.enable  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_X: prdata = DATA_W'(cfg_q.start_x);
			REG_START_Y: prdata = DATA_W'(cfg_q.start_y);
			REG_END_X:   prdata = DATA_W'(cfg_q.end_x);
			REG_END_Y:   prdata = DATA_W'(cfg_q.end_y);
			REG_ENABLE:  prdata = DATA_W'(cfg_q.enable);
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/lcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcc_ctrl
// Controller: clearing sweep after reset, word intake, and the table
// read-modify-write step that waits for a free output register.
// ----------------------------------------------------------------------------
module lcc_ctrl
	import lcc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (status.out_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== hw/rtl/lcc_dp.sv =====
// ----------------------------------------------------------------------------
// lcc_dp
// Datapath: side classification, per-track side table, saturating crossing
// counters and the output word register.
// ----------------------------------------------------------------------------
module lcc_dp
	import lcc_pkg::*;
#(
	parameter int MAX_TRACKS      = 256,
	parameter int COORD_FRAC_BITS = 4
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  cfg_t                 cfg,
	input  logic [S_TDATA_W-1:0] in_tdata,
	input  logic                 in_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(MAX_TRACKS);
	localparam int REF_W = COORD_W + COORD_FRAC_BITS;
	localparam int CMP_W = (REF_W > CENT_W) ? REF_W : CENT_W;

	// id to table slot, folded at elaboration
	logic [IDX_W-1:0] slot_lut [ID_SPAN];

	for (genvar i = 0; i < ID_SPAN; i++) begin : g_slot
		assign slot_lut[i] = IDX_W'(i % MAX_TRACKS);
	end

	side_t            mem [MAX_TRACKS];
	side_t            rd_s1;
	logic [IDX_W-1:0] slot_s1;
	logic             inact_s1;
	side_t            side_s1;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] ab_q;
	logic [CNT_W-1:0] ba_q;
	logic             m_tvalid_q;
	side_t            out_side_q;
	cross_t           out_cross_q;
	logic [CNT_W-1:0] out_ab_q;
	logic [CNT_W-1:0] out_ba_q;

	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;
	logic [CMP_W-1:0]   cx;
	logic [CMP_W-1:0]   cy;
	logic [CMP_W-1:0]   lx_pos;
	logic [CMP_W-1:0]   ly_pos;
	side_t              side_in;
	side_t              new_side;
	cross_t             cross_kind;
	logic [CNT_W-1:0]   ab_nx;
	logic [CNT_W-1:0]   ba_nx;
	logic [IDX_W-1:0]   slot_in;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	side_t              mem_wdata;

	// classification of the incoming word
	always_comb begin
		dx      = (cfg.start_x > cfg.end_x) ? cfg.start_x - cfg.end_x
		                                    : cfg.end_x - cfg.start_x;
		dy      = (cfg.start_y > cfg.end_y) ? cfg.start_y - cfg.end_y
		                                    : cfg.end_y - cfg.start_y;
		cx      = CMP_W'(in_tdata[23:8]);
		cy      = CMP_W'(in_tdata[39:24]);
		lx_pos  = CMP_W'(cfg.start_x) << COORD_FRAC_BITS;
		ly_pos  = CMP_W'(cfg.start_y) << COORD_FRAC_BITS;
		side_in = SIDE_NONE;
		if (cfg.enable) begin
			if (dx < dy) begin
				if (cx < lx_pos) begin
					side_in = SIDE_A;
				end else if (cx > lx_pos) begin
					side_in = SIDE_B;
				end
			end else if (dx > dy) begin
				if (cy > ly_pos) begin
					side_in = SIDE_A;
				end else if (cy < ly_pos) begin
					side_in = SIDE_B;
				end
			end
		end
	end

	assign slot_in = slot_lut[in_tdata[ID_W-1:0]];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			slot_s1  <= slot_in;
			inact_s1 <= in_tuser;
			side_s1  <= side_in;
			rd_s1    <= mem[slot_in];
		end
	end

	// table update and crossing decision
	always_comb begin
		new_side   = rd_s1;
		cross_kind = CROSS_NONE;
		if (inact_s1) begin
			new_side = SIDE_NONE;
		end else if (rd_s1 == SIDE_NONE) begin
			new_side = side_s1;
		end else if (side_s1 != rd_s1) begin
			new_side = SIDE_NONE;
			if (rd_s1 == SIDE_A && side_s1 == SIDE_B) begin
				cross_kind = CROSS_AB;
			end else if (rd_s1 == SIDE_B && side_s1 == SIDE_A) begin
				cross_kind = CROSS_BA;
			end
		end
		ab_nx = (cross_kind == CROSS_AB && ab_q != '1) ? ab_q + 1'b1 : ab_q;
		ba_nx = (cross_kind == CROSS_BA && ba_q != '1) ? ba_q + 1'b1 : ba_q;
	end

	assign mem_we    = cmd.clear | cmd.update;
	assign mem_waddr = cmd.clear ? clr_q : slot_s1;
	assign mem_wdata = cmd.clear ? SIDE_NONE : new_side;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			ab_q       <= '0;
			ba_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.update) begin
				ab_q       <= ab_nx;
				ba_q       <= ba_nx;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_side_q  <= side_s1;
			out_cross_q <= cross_kind;
			out_ab_q    <= ab_nx;
			out_ba_q    <= ba_nx;
		end
	end

	assign status.clr_last = (clr_q == IDX_W'(MAX_TRACKS - 1));
	assign status.out_free = ~m_tvalid_q | m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_ba_q, out_ab_q, out_cross_q, out_side_q};

endmodule

// ===== hw/rtl/line_crossing_counter.sv =====
// ----------------------------------------------------------------------------
// line_crossing_counter
// Counts tracked objects crossing a configured tripwire line.
// The input word is registered at intake; the update step then registers the
// result word, and waits while a previous result word is still waiting on m_tready.
// A new word is taken only after the side table read-modify-write completes.
// Reset: counters, state and output valid clear; a sweep over all MAX_TRACKS
// side table entries then clears the table, with s_tready low until it ends.
// ----------------------------------------------------------------------------
module line_crossing_counter
	import lcc_pkg::*;
#(
	parameter int MAX_TRACKS      = 256,
	parameter int COORD_FRAC_BITS = 4
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // track_id, centroid_x, centroid_y
	input  logic                 s_tuser,  // track_inactive
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // side_now, crossing, total_a_to_b,
	                                       // total_b_to_a, zero fill
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	lcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lcc_dp #(
		.MAX_TRACKS      (MAX_TRACKS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg      (cfg),
		.in_tdata (s_tdata),
		.in_tuser (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== hw/rtl/lcc_checker.sv =====
// ----------------------------------------------------------------------------
// lcc_checker
// Port-level checks of the line crossing counter, bound to the top level.
// ----------------------------------------------------------------------------
module lcc_checker
	import lcc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// one word in flight: intake closes after each word
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("input taken on consecutive cycles");

	// empty output side: the result word follows intake through the update state, without stalling
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
	else $error("result word late");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("stalled result word changed");

	// a crossing always lands on the far side
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:2] != CROSS_AB || m_tdata[1:0] == SIDE_B) &&
		             (m_tdata[3:2] != CROSS_BA || m_tdata[1:0] == SIDE_A))
	else $error("crossing and side disagree");

endmodule

bind line_crossing_counter lcc_checker u_lcc_checker (.*);
